### rtl/rit_pkg.sv
// Shared types and codes of the range indicator table.
// Used by rit_cell and range_indicator_table_top; depends on nothing else.
`default_nettype none
package rit_pkg;

  localparam int unsigned DefaultDepth = 32;
  localparam int unsigned MaxResults   = 32;
  localparam logic [30:0] TopOffset    = 31'h7FFF_FFFF;

  localparam logic [2:0] REQ_APPEND    = 3'd0;
  localparam logic [2:0] REQ_CLR_OVL   = 3'd1;
  localparam logic [2:0] REQ_CLR_ID    = 3'd2;
  localparam logic [2:0] REQ_QUERY     = 3'd3;
  localparam logic [2:0] REQ_TRACK     = 3'd4;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_INVALID  = 2'd1;
  localparam logic [1:0] STAT_NOMATCH  = 2'd2;
  localparam logic [1:0] STAT_FULL     = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SCAN
  } state_e;

  typedef struct packed {
    logic [63:0] user;
    logic [31:0] flags;
    logic [30:0] end_ofs;
    logic [30:0] start_ofs;
    logic [7:0]  style;
    logic [15:0] id;
  } entry_t;

  // Broadcast controls from the sequencer to every cell.
  typedef struct packed {
    logic        mark_en;
    logic        mode_all;
    logic        rotate;
    logic        compact;
    logic [15:0] id;
    logic [30:0] rs;
    logic [30:0] re;
  } ctl_t;

endpackage
`default_nettype wire

### rtl/rit_cell.sv
// One table cell: holds one entry and a removal mark, loads, shifts from its upper neighbor.
// Depends on rit_pkg.
`default_nettype none
module rit_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire rit_pkg::ctl_t   ctl_i,
  input  wire logic            in_range_i,
  input  wire logic            load_i,
  input  wire rit_pkg::entry_t load_ent_i,
  input  wire rit_pkg::entry_t nb_ent_i,
  input  wire logic            nb_mark_i,
  input  wire logic            kill_i,
  output logic                 kill_o,
  output rit_pkg::entry_t      ent_o,
  output logic                 mark_o
);

  rit_pkg::entry_t ent_q, ent_d;
  logic            mark_q, mark_d;
  logic            hit;
  logic            shift;

  always_comb begin
    if (ctl_i.mode_all) begin
      hit = in_range_i && (ctl_i.id == 16'd0 || ent_q.id == ctl_i.id);
    end else begin
      hit = in_range_i && ent_q.id == ctl_i.id &&
            ent_q.start_ofs < ctl_i.re && ctl_i.rs < ent_q.end_ofs;
    end
  end

  // A cell at or above the lowest marked cell moves down by one.
  assign kill_o = kill_i | mark_q;
  assign shift  = ctl_i.rotate | (ctl_i.compact & kill_o);

  always_comb begin
    ent_d  = ent_q;
    mark_d = mark_q;
    if (load_i) begin
      ent_d = load_ent_i;
    end else if (shift) begin
      ent_d = nb_ent_i;
    end
    if (ctl_i.mark_en) begin
      mark_d = hit;
    end else if (shift) begin
      mark_d = nb_mark_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_q <= 1'b0;
    end else begin
      mark_q <= mark_d;
    end
  end

  assign ent_o  = ent_q;
  assign mark_o = mark_q;

endmodule
`default_nettype wire

### rtl/range_indicator_table_top.sv
// Range indicator table: a chain of rit_cell entries plus the request sequencer.
// Depends on rit_pkg and rit_cell.
//
// Requests arrive on the slave stream; the request code travels in tuser and the
// arguments in tdata. Results leave on the master stream, one word per result,
// with tlast on the final word of each request.
// Append, bad arguments and unknown codes answer in the accept cycle: the word
// is valid on the next cycle. Clear requests mark the matching cells, then the
// lowest marked cell is squeezed out each cycle while cells above it move down,
// and the answer follows once no mark is left. Query and track edit rotate the
// whole chain once through the head cell; the head cell's single comparator or
// edit adder handles one entry per cycle while the rotation is not frozen.
// A query holds one match back so that the final word can carry tlast and the
// total count; only the first 32 matches are sent.
// When the receiver stalls, the output register holds its word; the rotation
// freezes only when the next match or the closing word needs that register.
// A new request is taken only while the sequencer is idle and the output
// register can take a word.
// Reset empties the table and drops any pending word; entry contents are not
// cleared, since only entries below the count are ever read.
`default_nettype none
module range_indicator_table_top #(
  parameter int unsigned TABLE_DEPTH = rit_pkg::DefaultDepth
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // tdata from bit 0: indicator_id, style, range_start, range_end,
  // new_range_end, flags, user_data, zero fill.
  input  wire logic [215:0] s_axis_tdata_i,
  // tuser: req_type.
  input  wire logic [2:0]   s_axis_tuser_i,
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // tdata from bit 0: status, entry_valid, out_id, out_style, out_start,
  // out_end, out_flags, out_user, match_count, zero fill.
  output logic [191:0]      m_axis_tdata_o,
  output logic              m_axis_tlast_o
);

  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  function automatic rit_pkg::entry_t track_fn(rit_pkg::entry_t h, logic [30:0] es,
                                               logic [30:0] ee, logic [30:0] ne);
    logic [31:0]     ts;
    logic [31:0]     te;
    logic [30:0]     s;
    rit_pkg::entry_t r;
    r  = h;
    ts = {1'b0, h.start_ofs} + {1'b0, ne} - {1'b0, ee};
    te = {1'b0, h.end_ofs} + {1'b0, ne} - {1'b0, ee};
    s  = (h.start_ofs > es) ? es : h.start_ofs;
    if (h.end_ofs <= es) begin
      r = h;
    end else if (h.start_ofs >= ee) begin
      r.start_ofs = ts[31] ? rit_pkg::TopOffset : ts[30:0];
      r.end_ofs   = te[31] ? rit_pkg::TopOffset : te[30:0];
    end else begin
      r.start_ofs = s;
      if (ne <= s) begin
        r.end_ofs = (s == rit_pkg::TopOffset) ? rit_pkg::TopOffset : 31'(s + 31'd1);
      end else begin
        r.end_ofs = ne;
      end
    end
    return r;
  endfunction

  // Input unpacking.
  logic [2:0]      in_req;
  rit_pkg::entry_t in_ent;
  logic [30:0]     in_ne;
  assign in_req           = s_axis_tuser_i;
  assign in_ent.id        = s_axis_tdata_i[15:0];
  assign in_ent.style     = s_axis_tdata_i[23:16];
  assign in_ent.start_ofs = s_axis_tdata_i[54:24];
  assign in_ent.end_ofs   = s_axis_tdata_i[85:55];
  assign in_ne            = s_axis_tdata_i[116:86];
  assign in_ent.flags     = s_axis_tdata_i[148:117];
  assign in_ent.user      = s_axis_tdata_i[212:149];

  rit_pkg::state_e state_q, state_d;
  logic            op_track_q, op_track_d;
  logic [30:0]     a_rs_q, a_rs_d, a_re_q, a_re_d, a_ne_q, a_ne_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic            removed_q, removed_d;
  logic            pend_v_q, pend_v_d;
  rit_pkg::entry_t pend_q, pend_d;
  logic [5:0]      pend_cnt_q, pend_cnt_d;
  logic [5:0]      total_q, total_d;
  logic [5:0]      emitted_q, emitted_d;
  logic            ov_q, ov_d;
  logic [1:0]      o_stat_q, o_stat_d;
  logic            o_ev_q, o_ev_d;
  rit_pkg::entry_t o_ent_q, o_ent_d;
  logic [5:0]      o_cnt_q, o_cnt_d;
  logic            o_last_q, o_last_d;

  rit_pkg::ctl_t   ctl;
  logic            load_en;
  logic            accept;
  logic            slot_free;
  logic [5:0]      total_inc;

  rit_pkg::entry_t ent  [TABLE_DEPTH];
  logic            mark [TABLE_DEPTH];
  logic            kill [TABLE_DEPTH+1];
  rit_pkg::entry_t head, head_next;
  logic            head_in;
  logic            head_hit;

  assign slot_free = !ov_q || m_axis_tready_i;
  assign accept    = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == rit_pkg::ST_IDLE) && slot_free;

  assign head      = ent[0];
  assign head_in   = idx_q < count_q;
  assign head_hit  = head_in && head.start_ofs <= a_rs_q && a_rs_q < head.end_ofs;
  assign head_next = (op_track_q && head_in) ? track_fn(head, a_rs_q, a_re_q, a_ne_q) : head;
  assign total_inc = (total_q == 6'd63) ? 6'd63 : 6'(total_q + 6'd1);
  assign kill[0]   = 1'b0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    rit_pkg::entry_t nb_ent;
    logic            nb_mark;
    if (i == TABLE_DEPTH - 1) begin : g_top
      assign nb_ent  = head_next;
      assign nb_mark = 1'b0;
    end else begin : g_mid
      assign nb_ent  = ent[i+1];
      assign nb_mark = mark[i+1];
    end
    rit_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .in_range_i (CW'(i) < count_q),
      .load_i     (load_en && count_q == CW'(i)),
      .load_ent_i (in_ent),
      .nb_ent_i   (nb_ent),
      .nb_mark_i  (nb_mark),
      .kill_i     (kill[i]),
      .kill_o     (kill[i+1]),
      .ent_o      (ent[i]),
      .mark_o     (mark[i])
    );
  end

  always_comb begin
    state_d    = state_q;
    op_track_d = op_track_q;
    a_rs_d     = a_rs_q;
    a_re_d     = a_re_q;
    a_ne_d     = a_ne_q;
    count_d    = count_q;
    idx_d      = idx_q;
    removed_d  = removed_q;
    pend_v_d   = pend_v_q;
    pend_d     = pend_q;
    pend_cnt_d = pend_cnt_q;
    total_d    = total_q;
    emitted_d  = emitted_q;
    ov_d       = ov_q && !m_axis_tready_i;
    o_stat_d   = o_stat_q;
    o_ev_d     = o_ev_q;
    o_ent_d    = o_ent_q;
    o_cnt_d    = o_cnt_q;
    o_last_d   = o_last_q;
    load_en    = 1'b0;
    ctl.mark_en  = 1'b0;
    ctl.mode_all = (in_req == rit_pkg::REQ_CLR_ID);
    ctl.rotate   = 1'b0;
    ctl.compact  = 1'b0;
    ctl.id       = in_ent.id;
    ctl.rs       = in_ent.start_ofs;
    ctl.re       = in_ent.end_ofs;

    unique case (state_q)
      rit_pkg::ST_IDLE: begin
        if (accept) begin
          // Default answer: a plain word; overwritten below where needed.
          ov_d     = 1'b1;
          o_stat_d = rit_pkg::STAT_INVALID;
          o_ev_d   = 1'b0;
          o_ent_d  = '0;
          o_cnt_d  = 6'd0;
          o_last_d = 1'b1;
          a_rs_d   = in_ent.start_ofs;
          a_re_d   = in_ent.end_ofs;
          a_ne_d   = in_ne;
          case (in_req)
            rit_pkg::REQ_APPEND: begin
              if (in_ent.id == 16'd0 || in_ent.end_ofs <= in_ent.start_ofs) begin
                o_stat_d = rit_pkg::STAT_INVALID;
              end else if (count_q >= CW'(TABLE_DEPTH)) begin
                o_stat_d = rit_pkg::STAT_FULL;
              end else begin
                load_en  = 1'b1;
                count_d  = CW'(count_q + CW'(1));
                o_stat_d = rit_pkg::STAT_OK;
              end
            end
            rit_pkg::REQ_CLR_OVL, rit_pkg::REQ_CLR_ID: begin
              if (in_req == rit_pkg::REQ_CLR_OVL &&
                  (in_ent.id == 16'd0 || in_ent.end_ofs <= in_ent.start_ofs)) begin
                o_stat_d = rit_pkg::STAT_INVALID;
              end else begin
                ov_d        = 1'b0;
                ctl.mark_en = 1'b1;
                removed_d   = 1'b0;
                state_d     = rit_pkg::ST_CLEAR;
              end
            end
            rit_pkg::REQ_QUERY, rit_pkg::REQ_TRACK: begin
              if (in_req == rit_pkg::REQ_TRACK &&
                  (in_ent.end_ofs < in_ent.start_ofs || in_ne < in_ent.start_ofs)) begin
                o_stat_d = rit_pkg::STAT_INVALID;
              end else begin
                ov_d       = 1'b0;
                op_track_d = (in_req == rit_pkg::REQ_TRACK);
                idx_d      = '0;
                pend_v_d   = 1'b0;
                total_d    = 6'd0;
                emitted_d  = 6'd0;
                state_d    = rit_pkg::ST_SCAN;
              end
            end
            default: begin
              o_stat_d = rit_pkg::STAT_INVALID;
            end
          endcase
        end
      end
      rit_pkg::ST_CLEAR: begin
        if (kill[TABLE_DEPTH]) begin
          ctl.compact = 1'b1;
          count_d     = CW'(count_q - CW'(1));
          removed_d   = 1'b1;
        end else if (slot_free) begin
          ov_d     = 1'b1;
          o_stat_d = removed_q ? rit_pkg::STAT_OK : rit_pkg::STAT_NOMATCH;
          o_ev_d   = 1'b0;
          o_ent_d  = '0;
          o_cnt_d  = 6'd0;
          o_last_d = 1'b1;
          state_d  = rit_pkg::ST_IDLE;
        end
      end
      rit_pkg::ST_SCAN: begin
        if (idx_q == CW'(TABLE_DEPTH)) begin
          if (slot_free) begin
            ov_d     = 1'b1;
            o_stat_d = rit_pkg::STAT_OK;
            o_last_d = 1'b1;
            if (!op_track_q && pend_v_q) begin
              o_ev_d  = 1'b1;
              o_ent_d = pend_q;
              o_cnt_d = total_q;
            end else begin
              o_ev_d  = 1'b0;
              o_ent_d = '0;
              o_cnt_d = 6'd0;
            end
            pend_v_d = 1'b0;
            state_d  = rit_pkg::ST_IDLE;
          end
        end else if (!op_track_q && head_hit && emitted_q < 6'(rit_pkg::MaxResults)) begin
          // A new match pushes the held one out first.
          if (!pend_v_q || slot_free) begin
            if (pend_v_q) begin
              ov_d     = 1'b1;
              o_stat_d = rit_pkg::STAT_OK;
              o_ev_d   = 1'b1;
              o_ent_d  = pend_q;
              o_cnt_d  = pend_cnt_q;
              o_last_d = 1'b0;
            end
            pend_v_d   = 1'b1;
            pend_d     = head;
            pend_cnt_d = total_inc;
            total_d    = total_inc;
            emitted_d  = 6'(emitted_q + 6'd1);
            ctl.rotate = 1'b1;
            idx_d      = CW'(idx_q + CW'(1));
          end
        end else begin
          if (!op_track_q && head_hit) begin
            total_d = total_inc;
          end
          ctl.rotate = 1'b1;
          idx_d      = CW'(idx_q + CW'(1));
        end
      end
      default: begin
        state_d = rit_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rit_pkg::ST_IDLE;
      count_q   <= '0;
      idx_q     <= '0;
      removed_q <= 1'b0;
      pend_v_q  <= 1'b0;
      total_q   <= 6'd0;
      emitted_q <= 6'd0;
      ov_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      idx_q     <= idx_d;
      removed_q <= removed_d;
      pend_v_q  <= pend_v_d;
      total_q   <= total_d;
      emitted_q <= emitted_d;
      ov_q      <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_track_q <= op_track_d;
    a_rs_q     <= a_rs_d;
    a_re_q     <= a_re_d;
    a_ne_q     <= a_ne_d;
    pend_q     <= pend_d;
    pend_cnt_q <= pend_cnt_d;
    o_stat_q   <= o_stat_d;
    o_ev_q     <= o_ev_d;
    o_ent_q    <= o_ent_d;
    o_cnt_q    <= o_cnt_d;
    o_last_q   <= o_last_d;
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tlast_o  = o_last_q;
  assign m_axis_tdata_o  = {1'b0, o_cnt_q, o_ent_q.user, o_ent_q.flags, o_ent_q.end_ofs,
                            o_ent_q.start_ofs, o_ent_q.style, o_ent_q.id, o_ev_q, o_stat_q};

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TABLE_DEPTH)) else $error("entry count above table depth");
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> state_q == rit_pkg::ST_IDLE) else $error("ready while busy");
  a_pend_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_v_q |-> state_q == rit_pkg::ST_SCAN) else $error("held match outside a scan");
  a_emit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emitted_q <= 6'(rit_pkg::MaxResults)) else $error("too many matches sent");

endmodule
`default_nettype wire

### bench/tb.sv
// Self-checking bench for range_indicator_table_top: requests stream in, results are
// predicted by a behavioral table model inside this file and compared word by word.
// Depends on rit_pkg and the RTL of the block.
`timescale 1ns / 1ps
module tb;
  import rit_pkg::*;

  localparam int Depth = 32;
  localparam longint CycleLimit = 400000;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] id;
    logic [7:0]  style;
    logic [30:0] rs;
    logic [30:0] re;
    logic [30:0] ne;
    logic [31:0] flags;
    logic [63:0] user;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        hit;
    logic [15:0] id;
    logic [7:0]  style;
    logic [30:0] s;
    logic [30:0] e;
    logic [31:0] flags;
    logic [63:0] user;
    logic [5:0]  count;
    logic        last;
  } res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [215:0] s_axis_tdata_i = '0;
  logic [2:0] s_axis_tuser_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [191:0] m_axis_tdata_o;
  logic m_axis_tlast_o;

  range_indicator_table_top #(.TABLE_DEPTH(Depth)) uut (
    .clk_i, .rst_ni, .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i,
    .s_axis_tuser_i, .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o,
    .m_axis_tlast_o
  );

  // Shadow copy of the table.
  int unsigned shadow_count;
  entry_t shadow_tab[Depth];

  req_t pending_reqs[$];
  res_t expected_words[$];
  int errors = 0;
  longint cycles = 0;
  bit quiet_span = 1'b0;   // no idling on either side while set
  bit hold_send = 1'b0;    // sender holds off while set

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic res_t plain_word(logic [1:0] st);
    res_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic logic [30:0] shift_sat(logic [30:0] v, logic [30:0] oe, logic [30:0] ne);
    longint r;
    r = longint'(v) + longint'(ne) - longint'(oe);
    return (r > longint'(TopOffset)) ? TopOffset : r[30:0];
  endfunction

  // Removes matching entries in place; all_mode selects clear by id.
  function automatic int squeeze_out(bit all_mode, req_t q);
    int keep;
    int gone;
    bit hit;
    keep = 0;
    gone = 0;
    for (int i = 0; i < shadow_count; i++) begin
      if (all_mode) hit = (q.id == 0) || (shadow_tab[i].id == q.id);
      else hit = shadow_tab[i].id == q.id && shadow_tab[i].start_ofs < q.re &&
                 q.rs < shadow_tab[i].end_ofs;
      if (hit) gone++;
      else begin
        shadow_tab[keep] = shadow_tab[i];
        keep++;
      end
    end
    shadow_count = keep;
    return gone;
  endfunction

  task automatic predict_request(req_t q);
    int total;
    int sent;
    logic [30:0] s;
    logic [30:0] e;
    res_t w;
    case (q.kind)
      REQ_APPEND: begin
        if (q.id == 0 || q.re <= q.rs) expected_words.push_back(plain_word(STAT_INVALID));
        else if (shadow_count >= Depth) expected_words.push_back(plain_word(STAT_FULL));
        else begin
          shadow_tab[shadow_count] = '{user: q.user, flags: q.flags, end_ofs: q.re,
                                       start_ofs: q.rs, style: q.style, id: q.id};
          shadow_count++;
          expected_words.push_back(plain_word(STAT_OK));
        end
      end
      REQ_CLR_OVL: begin
        if (q.id == 0 || q.re <= q.rs) expected_words.push_back(plain_word(STAT_INVALID));
        else expected_words.push_back(plain_word(squeeze_out(0, q) ? STAT_OK : STAT_NOMATCH));
      end
      REQ_CLR_ID: expected_words.push_back(plain_word(squeeze_out(1, q) ? STAT_OK : STAT_NOMATCH));
      REQ_QUERY: begin
        total = 0;
        sent = 0;
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_tab[i].start_ofs <= q.rs && q.rs < shadow_tab[i].end_ofs) begin
            total++;
            if (sent < MaxResults) begin
              w = '0;
              w.status = STAT_OK;
              w.hit = 1'b1;
              w.id = shadow_tab[i].id;
              w.style = shadow_tab[i].style;
              w.s = shadow_tab[i].start_ofs;
              w.e = shadow_tab[i].end_ofs;
              w.flags = shadow_tab[i].flags;
              w.user = shadow_tab[i].user;
              w.count = (total > 63) ? 6'd63 : 6'(total);
              expected_words.push_back(w);
              sent++;
            end
          end
        end
        if (sent == 0) expected_words.push_back(plain_word(STAT_OK));
        else begin
          w = expected_words.pop_back();
          w.count = (total > 63) ? 6'd63 : 6'(total);
          w.last = 1'b1;
          expected_words.push_back(w);
        end
      end
      REQ_TRACK: begin
        if (q.re < q.rs || q.ne < q.rs) expected_words.push_back(plain_word(STAT_INVALID));
        else begin
          for (int i = 0; i < shadow_count; i++) begin
            s = shadow_tab[i].start_ofs;
            e = shadow_tab[i].end_ofs;
            if (e <= q.rs) continue;
            if (s >= q.re) begin
              shadow_tab[i].start_ofs = shift_sat(s, q.re, q.ne);
              shadow_tab[i].end_ofs = shift_sat(e, q.re, q.ne);
            end else begin
              if (s > q.rs) s = q.rs;
              e = q.ne;
              if (e <= s) e = (s >= TopOffset) ? TopOffset : s + 31'd1;
              shadow_tab[i].start_ofs = s;
              shadow_tab[i].end_ofs = e;
            end
          end
          expected_words.push_back(plain_word(STAT_OK));
        end
      end
      default: expected_words.push_back(plain_word(STAT_INVALID));
    endcase
  endtask

  // Driver: presents the queue head; prediction happens on acceptance.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        predict_request(pending_reqs.pop_front());
      end
      if ((!s_axis_tvalid_i || s_axis_tready_o)) begin
        if (s_axis_tvalid_i && s_axis_tready_o && pending_reqs.size() == 0) begin
          s_axis_tvalid_i <= 1'b0;
        end else if (pending_reqs.size() > 0 && !hold_send &&
                     (quiet_span || $urandom_range(99) >= 36)) begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tuser_i <= pending_reqs[0].kind;
          s_axis_tdata_i <= {3'b0, pending_reqs[0].user, pending_reqs[0].flags,
                             pending_reqs[0].ne, pending_reqs[0].re, pending_reqs[0].rs,
                             pending_reqs[0].style, pending_reqs[0].id};
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result word and drives a random stall.
  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    cycles <= cycles + 1;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = '0;
        {got.count, got.user, got.flags, got.e, got.s, got.style, got.id, got.hit,
         got.status} = m_axis_tdata_o[190:0];
        got.last = m_axis_tlast_o;
        if (expected_words.size() == 0) begin
          errors <= errors + 1;
          $display("%0t: unexpected word %h last %b", $time, m_axis_tdata_o, m_axis_tlast_o);
        end else begin
          want = expected_words.pop_front();
          if (got != want || m_axis_tdata_o[191] != 1'b0) begin
            errors <= errors + 1;
            $display("%0t: expected %h actual %h", $time, want, got);
          end
        end
      end
      m_axis_tready_i <= quiet_span || ($urandom_range(99) >= 36);
    end
  end

  function automatic logic [30:0] rand_ofs();
    case ($urandom_range(5))
      0: return TopOffset - 31'($urandom_range(3));
      1: return 31'($urandom);
      default: return 31'($urandom_range(60));
    endcase
  endfunction

  function automatic req_t rand_req();
    req_t q;
    q.kind = ($urandom_range(30) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
    if (q.kind == REQ_APPEND && $urandom_range(1)) q.kind = REQ_APPEND;
    q.id = ($urandom_range(15) == 0) ? 16'($urandom) : 16'($urandom_range(4));
    if ($urandom_range(40) == 0) q.id = 16'hFFFF;
    q.style = 8'($urandom);
    q.rs = rand_ofs();
    q.re = ($urandom_range(9) == 0) ? rand_ofs() : q.rs + 31'($urandom_range(20));
    q.ne = ($urandom_range(9) == 0) ? rand_ofs() : q.rs + 31'($urandom_range(20));
    q.flags = $urandom;
    q.user = {$urandom, $urandom};
    return q;
  endfunction

  function automatic req_t mk(logic [2:0] k, logic [15:0] id, logic [30:0] rs,
                              logic [30:0] re, logic [30:0] ne);
    req_t q;
    q = rand_req();
    q.kind = k;
    q.id = id;
    q.rs = rs;
    q.re = re;
    q.ne = ne;
    return q;
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || s_axis_tvalid_i || expected_words.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    shadow_count = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Directed part: argument checks, all codes, extremes and saturation.
    pending_reqs.push_back(mk(REQ_QUERY, 0, 5, 0, 0));
    pending_reqs.push_back(mk(REQ_APPEND, 0, 1, 5, 0));
    pending_reqs.push_back(mk(REQ_APPEND, 1, 5, 5, 0));
    pending_reqs.push_back(mk(REQ_APPEND, 16'hFFFF, 0, TopOffset, 0));
    pending_reqs.push_back(mk(REQ_APPEND, 2, TopOffset - 2, TopOffset, 0));
    pending_reqs.push_back(mk(REQ_APPEND, 3, 10, 20, 0));
    pending_reqs.push_back(mk(REQ_QUERY, 0, 15, 0, 0));
    pending_reqs.push_back(mk(REQ_TRACK, 0, 10, 5, 12));
    pending_reqs.push_back(mk(REQ_TRACK, 0, 10, 12, 5));
    pending_reqs.push_back(mk(REQ_TRACK, 0, 25, 30, 40));
    pending_reqs.push_back(mk(REQ_TRACK, 0, 12, 15, 12));
    pending_reqs.push_back(mk(REQ_QUERY, 0, TopOffset - 1, 0, 0));
    pending_reqs.push_back(mk(REQ_CLR_OVL, 0, 1, 5, 0));
    pending_reqs.push_back(mk(REQ_CLR_OVL, 3, 9, 9, 0));
    pending_reqs.push_back(mk(REQ_CLR_OVL, 7, 0, TopOffset, 0));
    pending_reqs.push_back(mk(REQ_CLR_OVL, 3, 0, TopOffset, 0));
    pending_reqs.push_back(mk(3'd5, 1, 0, 0, 0));
    pending_reqs.push_back(mk(3'd7, 1, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_CLR_ID, 9, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_CLR_ID, 16'hFFFF, 0, 0, 0));
    // Fill past capacity with overlapping ranges; the query then hits all 31 that fit.
    for (int i = 0; i < 34; i++) pending_reqs.push_back(mk(REQ_APPEND, 5, 0, 100, 0));
    pending_reqs.push_back(mk(REQ_QUERY, 0, 50, 0, 0));
    pending_reqs.push_back(mk(REQ_TRACK, 0, 0, TopOffset, TopOffset));
    pending_reqs.push_back(mk(REQ_QUERY, 0, 50, 0, 0));
    pending_reqs.push_back(mk(REQ_CLR_ID, 0, 0, 0, 0));
    wait_drained();
    // Once the block has answered everything, the sender is held off before the random part.
    hold_send = 1'b1;
    repeat (50) @(posedge clk_i);
    hold_send = 1'b0;
    // Random part with a quiet stretch in the middle.
    for (int i = 0; i < 250; i++) begin
      if (i % 60 == 0 && $urandom_range(2) == 0) pending_reqs.push_back(mk(REQ_CLR_ID, 0, 0, 0, 0));
      pending_reqs.push_back(rand_req());
      if (i == 120) begin
        wait_drained();
        quiet_span = 1'b1;
      end
      if (i == 180) begin
        wait_drained();
        quiet_span = 1'b0;
      end
    end
    wait_drained();
    repeat (80) @(posedge clk_i);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("range_indicator_table_top: match");
    end else begin
      $display("range_indicator_table_top: mismatch");
    end
    $finish;
  end

  initial begin
    wait (cycles >= CycleLimit);
    $display("range_indicator_table_top: mismatch");
    $finish;
  end

endmodule
